// ----- rtl/core/fra_pkg.sv -----
package fra_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Magnitude width of the divider and the Euclid operands
  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);
  // Width of the signed cross products
  localparam int PRD_W = 33;

  // Queue depth between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Classified transaction handed from front to back
  typedef struct packed {
    logic signed [PRD_W-1:0] n;
    logic signed [PRD_W-1:0] d;
    logic                    dz;
  } fra_item_t;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } fra_div_req_t;

endpackage

// ----- rtl/core/fraction_arith_reduce_unit.sv -----
// Each transaction passes the front product register and the queue; the back then runs the
// Euclid remainder steps and the two final quotients, or skips the divider for a divide by a
// zero fraction. The back takes the next queued transaction only after the last result is
// registered; the shared 1-bit-per-cycle divider, used for all these divides, sets the pace.
// A 4-entry queue lets the front keep accepting while the back divides.
// Reset (rst, synchronous, active high) empties the queue and the result register.
module fraction_arith_reduce_unit import fra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind,
  input  logic signed [15:0] num_a,
  input  logic [14:0]        den_a,
  input  logic signed [15:0] num_b,
  input  logic [14:0]        den_b,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] num_out,
  output logic signed [30:0] den_out,
  output logic               div_zero
);

  logic      q_wr, q_full, q_rd, q_vld;
  fra_item_t wr_item, rd_item;

  fra_front u_front (
    .clk (clk), .rst (rst), .push (push), .full (full),
    .kind (kind), .num_a (num_a), .den_a (den_a), .num_b (num_b), .den_b (den_b),
    .q_wr (q_wr), .q_item (wr_item), .q_full (q_full)
  );

  fra_queue u_queue (
    .clk (clk), .rst (rst), .wr (q_wr), .wr_item (wr_item), .q_full (q_full),
    .rd (q_rd), .rd_item (rd_item), .q_vld (q_vld)
  );

  fra_back u_back (
    .clk (clk), .rst (rst), .q_vld (q_vld), .q_item (rd_item), .q_rd (q_rd),
    .empty (empty), .pop (pop), .num_out (num_out), .den_out (den_out),
    .div_zero (div_zero)
  );

endmodule

// ----- rtl/core/fra_front.sv -----
module fra_front import fra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind,
  input  logic signed [15:0] num_a,
  input  logic [14:0]        den_a,
  input  logic signed [15:0] num_b,
  input  logic [14:0]        den_b,
  output logic               q_wr,
  output fra_item_t          q_item,
  input  logic               q_full
);

  logic                    vld;
  logic [1:0]              kind_r;
  logic                    dz_r;
  logic signed [PRD_W-1:0] p1;
  logic signed [PRD_W-1:0] p2;
  logic signed [PRD_W-1:0] p3;

  logic signed [16:0] na_x, nb_x, da_x, db_x, m1_x;
  logic signed [33:0] m1, m2, m3;
  logic               take;

  assign na_x = {num_a[15], num_a};
  assign nb_x = {num_b[15], num_b};
  assign da_x = {2'b00, den_a};
  assign db_x = {2'b00, den_b};
  assign m1_x = (kind == OP_MUL) ? nb_x : db_x;
  assign m1   = na_x * m1_x;
  assign m2   = nb_x * da_x;
  assign m3   = da_x * db_x;

  assign full = vld && q_full;
  assign take = push && !full;
  assign q_wr = vld && !q_full;

  // Hold products until the queue takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (q_wr) begin
      vld <= 1'b0;
    end
    if (take) begin
      kind_r <= kind;
      dz_r   <= (kind == OP_DIV) && (num_b == 16'sd0);
      p1     <= m1[PRD_W-1:0];
      p2     <= m2[PRD_W-1:0];
      p3     <= m3[PRD_W-1:0];
    end
  end

  // Combine products into numerator and denominator
  always_comb begin
    q_item.dz = dz_r;
    q_item.d  = (kind_r == OP_DIV) ? p2 : p3;
    case (kind_r)
      OP_ADD:  q_item.n = p1 + p2;
      OP_SUB:  q_item.n = p1 - p2;
      default: q_item.n = p1;
    endcase
  end

endmodule

// ----- rtl/core/fra_queue.sv -----
module fra_queue import fra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  fra_item_t wr_item,
  output logic      q_full,
  input  logic      rd,
  output fra_item_t rd_item,
  output logic      q_vld
);

  fra_item_t        slots [Q_DEPTH];
  logic [Q_AW-1:0]  wp, rp;
  logic [Q_AW:0]    cnt;

  assign q_full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign q_vld   = (cnt != '0);
  assign rd_item = slots[rp];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      if (wr && !rd) cnt <= cnt + 1'b1;
      else if (rd && !wr) cnt <= cnt - 1'b1;
    end
    if (wr) slots[wp] <= wr_item;
  end

endmodule

// ----- rtl/core/fra_div.sv -----
module fra_div import fra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  fra_div_req_t     req,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [DIV_W-1:0] rem
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             qbit;

  // One quotient bit per cycle, restoring
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign qbit    = !diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem  <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo  <= {quo[DIV_W-2:0], qbit};
        cnt  <= cnt + 1'b1;
        done <= (cnt == CNT_W'(DIV_W-1));
        if (cnt == CNT_W'(DIV_W-1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/fra_back.sv -----
module fra_back import fra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_vld,
  input  fra_item_t          q_item,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] num_out,
  output logic signed [30:0] den_out,
  output logic               div_zero
);

  typedef enum logic [2:0] {
    S_IDLE, S_EUC, S_EWAIT, S_QNW, S_QDW, S_OUT
  } state_t;

  state_t           state;
  logic [DIV_W-1:0] a, b, mn, md, qn, qd;
  logic             par, sn, sd, sg, dz, zero;
  logic             out_vld;

  fra_div_req_t     req;
  logic             done;
  logic [DIV_W-1:0] quo, rem;
  logic [PRD_W-1:0] n_abs, d_abs;
  logic [DIV_W-1:0] qn_s, qd_s;

  fra_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (done),
    .quo  (quo),
    .rem  (rem)
  );

  assign n_abs = q_item.n[PRD_W-1] ? -q_item.n : q_item.n;
  assign d_abs = q_item.d[PRD_W-1] ? -q_item.d : q_item.d;
  assign q_rd  = (state == S_IDLE) && q_vld;
  assign empty = !out_vld;

  // Launch remainder steps and the two final quotients
  always_comb begin
    req.start    = 1'b0;
    req.dividend = md;
    req.divisor  = a;
    if (state == S_EUC) begin
      req.start    = (b != '0) || (a != '0);
      req.dividend = (b == '0) ? mn : a;
      req.divisor  = (b == '0) ? a : b;
    end else if (state == S_QNW) begin
      req.start = done;
    end
  end

  // Apply result signs
  assign qn_s = (sn ^ sg) ? -qn : qn;
  assign qd_s = (sd ^ sg) ? -qd : qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      // Set on a new result, clear on a pop
      if ((state == S_OUT) && (!out_vld || pop)) out_vld <= 1'b1;
      else if (pop) out_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_vld) begin
            sn    <= q_item.n[PRD_W-1];
            sd    <= q_item.d[PRD_W-1];
            mn    <= n_abs[DIV_W-1:0];
            md    <= d_abs[DIV_W-1:0];
            a     <= n_abs[DIV_W-1:0];
            b     <= d_abs[DIV_W-1:0];
            par   <= 1'b0;
            dz    <= q_item.dz;
            zero  <= q_item.dz;
            state <= q_item.dz ? S_OUT : S_EUC;
          end
        end
        S_EUC: begin
          if (b == '0) begin
            sg <= par ? sd : sn;
            if (a == '0) begin
              zero  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_QNW;
            end
          end else begin
            state <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (done) begin
            a     <= b;
            b     <= rem;
            par   <= !par;
            state <= S_EUC;
          end
        end
        S_QNW: begin
          if (done) begin
            qn    <= quo;
            state <= S_QDW;
          end
        end
        S_QDW: begin
          if (done) begin
            qd    <= quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld || pop) begin
            div_zero <= dz;
            num_out  <= zero ? '0 : qn_s;
            den_out  <= zero ? '0 : qd_s[30:0];
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/fra_checker.sv -----
module fra_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] num_out,
  input logic signed [30:0] den_out,
  input logic               div_zero
);

  // Reset leaves no result waiting and room for input
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("reset did not clear queue state");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(num_out) && $stable(den_out)
                          && $stable(div_zero)))
    else $error("waiting result changed");

  // Divide-by-zero transactions give zero fields
  a_dz: assert property (@(posedge clk) disable iff (rst)
    (!empty && div_zero) |-> (num_out == 32'sd0 && den_out == 31'sd0))
    else $error("div_zero with nonzero fields");

  // Zero denominator reduces numerator to 0 or a unit
  a_zden: assert property (@(posedge clk) disable iff (rst)
    (!empty && den_out == 31'sd0) |->
      (num_out == 32'sd0 || num_out == 32'sd1 || num_out == -32'sd1))
    else $error("zero denominator not reduced");

endmodule

bind fraction_arith_reduce_unit fra_checker u_chk (.*);
